>>> rtl/utf8v_pkg.sv
// ----------------------------------------------------------------------------
// utf8v_pkg: shared types, codes and lead-byte table for the UTF-8 checker
// Status codes, the offset width, the result word and the lead-byte decode.
// ----------------------------------------------------------------------------
package utf8v_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int OUT_BITS    = 32;

    typedef logic [OFFSET_BITS-1:0] offset_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_LEAD     = 3'd1,
        ST_TRUNC    = 3'd2,
        ST_CONT     = 3'd3,
        ST_OVERLONG = 3'd4,
        ST_SURR     = 3'd5,
        ST_RANGE    = 3'd6
    } status_t;

    typedef struct packed {
        status_t               status;
        logic [OUT_BITS-1:0]   bad_offset;
    } result_t;

    typedef struct packed {
        logic [2:0] len;
        logic [7:0] lo;
        logic [7:0] hi;
        status_t    code;
    } lead_row_t;

    localparam logic [7:0] CONT_LO     = 8'h80;
    localparam logic [7:0] CONT_HI     = 8'hBF;
    localparam logic [7:0] E0_LO       = 8'hA0;
    localparam logic [7:0] ED_HI       = 8'h9F;
    localparam logic [7:0] F0_LO       = 8'h90;
    localparam logic [7:0] F4_HI       = 8'h8F;
    localparam logic [7:0] LEAD_C0     = 8'hC0;
    localparam logic [7:0] LEAD_C2     = 8'hC2;
    localparam logic [7:0] LEAD_E0     = 8'hE0;
    localparam logic [7:0] LEAD_ED     = 8'hED;
    localparam logic [7:0] LEAD_F0     = 8'hF0;
    localparam logic [7:0] LEAD_F4     = 8'hF4;
    localparam logic [7:0] LEAD_F8     = 8'hF8;

    function automatic lead_row_t lead_row(input logic [7:0] b);
        lead_row_t r;
        r.len  = 3'd0;
        r.lo   = CONT_LO;
        r.hi   = CONT_HI;
        r.code = ST_OK;
        priority if (b < CONT_LO) begin
            r.len = 3'd1;
        end
        else if (b < LEAD_C0) begin
            r.code = ST_LEAD;
        end
        else if (b < LEAD_C2) begin
            r.code = ST_OVERLONG;
        end
        else if (b < LEAD_E0) begin
            r.len = 3'd2;
        end
        else if (b == LEAD_E0) begin
            r.len  = 3'd3;
            r.lo   = E0_LO;
            r.code = ST_OVERLONG;
        end
        else if (b == LEAD_ED) begin
            r.len  = 3'd3;
            r.hi   = ED_HI;
            r.code = ST_SURR;
        end
        else if (b < LEAD_F0) begin
            r.len = 3'd3;
        end
        else if (b == LEAD_F0) begin
            r.len  = 3'd4;
            r.lo   = F0_LO;
            r.code = ST_OVERLONG;
        end
        else if (b < LEAD_F4) begin
            r.len = 3'd4;
        end
        else if (b == LEAD_F4) begin
            r.len  = 3'd4;
            r.hi   = F4_HI;
            r.code = ST_RANGE;
        end
        else if (b < LEAD_F8) begin
            r.code = ST_RANGE;
        end
        else begin
            r.code = ST_LEAD;
        end
        return r;
    endfunction

    function automatic logic [OUT_BITS-1:0] to_out(input offset_t v);
        logic [63:0] w;
        w = 64'(v);
        return w[OUT_BITS-1:0];
    endfunction

endpackage

>>> rtl/utf8v_byte_if.sv
// ----------------------------------------------------------------------------
// utf8v_byte_if: byte channel into the UTF-8 checker
// Valid/ready handshake carrying one buffer byte and its last-byte flag.
// ----------------------------------------------------------------------------
interface utf8v_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_of_buffer;

    modport source (output valid, output data_byte, output last_of_buffer, input ready);
    modport sink   (input valid, input data_byte, input last_of_buffer, output ready);
endinterface

>>> rtl/utf8v_result_if.sv
// ----------------------------------------------------------------------------
// utf8v_result_if: result channel out of the UTF-8 checker
// Valid/ready handshake carrying a status code and an offset or byte count.
// ----------------------------------------------------------------------------
interface utf8v_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] bad_offset;

    modport source (output valid, output status, output bad_offset, input ready);
    modport sink   (input valid, input status, input bad_offset, output ready);
endinterface

>>> rtl/utf8_validator.sv
// ----------------------------------------------------------------------------
// utf8_validator: streaming UTF-8 well-formedness checker
// An accepted byte is held in the input register; when the core fires on it,
// any result it produces loads into the result register. Throughput: one
// byte per cycle, set by the state update in the core; stalls only while a
// result waits downstream.
// Reset: rst_n clears position, sequence state and both valid flags at once.
// ----------------------------------------------------------------------------
module utf8_validator (
    input  logic           clk,
    input  logic           rst_n,
    utf8v_byte_if.sink     data,
    utf8v_result_if.source result
);
    import utf8v_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       accept;
    logic       fire;
    logic       emit;
    logic       out_free;
    result_t    core_result;

    assign fire       = in_valid_reg && (!emit || out_free);
    assign data.ready = !in_valid_reg || fire;
    assign accept     = data.valid && data.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= data.data_byte;
            in_last_reg <= data.last_of_buffer;
        end
    end

    utf8v_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .data_byte      (in_byte_reg),
        .last_of_buffer (in_last_reg),
        .emit           (emit),
        .result         (core_result)
    );

    utf8v_outreg u_outreg (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (fire && emit),
        .result (core_result),
        .free   (out_free),
        .out    (result)
    );

endmodule

>>> rtl/utf8v_core.sv
// ----------------------------------------------------------------------------
// utf8v_core: sequence state and per-byte decision
// Holds the position and open-sequence state and decides, for one registered
// byte, whether a result is due and what it carries.
// ----------------------------------------------------------------------------
module utf8v_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  logic [7:0]         data_byte,
    input  logic               last_of_buffer,
    output logic               emit,
    output utf8v_pkg::result_t result
);
    import utf8v_pkg::*;

    offset_t    pos_reg,    pos_next;
    offset_t    start_reg,  start_next;
    logic [2:0] len_reg,    len_next;
    logic [2:0] seen_reg,   seen_next;
    logic [7:0] lo_reg,     lo_next;
    logic [7:0] hi_reg,     hi_next;
    status_t    ncode_reg,  ncode_next;
    status_t    pcode_reg,  pcode_next;
    logic       pflag_reg,  pflag_next;
    logic       swallow_reg, swallow_next;

    offset_t    pos_inc;
    lead_row_t  row;
    logic       bad;
    status_t    code;
    logic       eff_flag;
    status_t    eff_code;
    logic [2:0] seen_inc;
    logic       do_emit;
    status_t    em_status;
    offset_t    em_off;

    assign pos_inc  = (pos_reg == '1) ? pos_reg : pos_reg + OFFSET_BITS'(1);
    assign row      = lead_row(data_byte);
    assign bad      = (data_byte < CONT_LO) || (data_byte > CONT_HI);
    assign seen_inc = seen_reg + 3'd1;

    always_comb
    begin
        code = ST_OK;
        if (bad)
        begin
            code = ST_CONT;
        end
        else if (seen_reg == 3'd1 && (data_byte < lo_reg || data_byte > hi_reg))
        begin
            code = ncode_reg;
        end
    end

    assign eff_flag = pflag_reg || (code != ST_OK);
    assign eff_code = pflag_reg ? pcode_reg : code;

    always_comb
    begin
        pos_next     = pos_reg;
        start_next   = start_reg;
        len_next     = len_reg;
        seen_next    = seen_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        ncode_next   = ncode_reg;
        pcode_next   = pcode_reg;
        pflag_next   = pflag_reg;
        swallow_next = swallow_reg;
        do_emit      = 1'b0;
        em_status    = ST_OK;
        em_off       = pos_reg;

        if (swallow_reg)
        begin
            pos_next = pos_inc;
        end
        else if (len_reg != 3'd0)
        begin
            if (seen_inc >= len_reg)
            begin
                if (eff_flag)
                begin
                    do_emit   = 1'b1;
                    em_status = eff_code;
                    em_off    = start_reg;
                end
                else
                begin
                    len_next  = 3'd0;
                    seen_next = 3'd0;
                    pos_next  = pos_inc;
                    if (last_of_buffer)
                    begin
                        do_emit   = 1'b1;
                        em_status = ST_OK;
                        em_off    = pos_inc;
                    end
                end
            end
            else if (last_of_buffer)
            begin
                do_emit   = 1'b1;
                em_status = ST_TRUNC;
                em_off    = start_reg;
            end
            else
            begin
                seen_next  = seen_inc;
                pflag_next = eff_flag;
                pcode_next = eff_code;
                pos_next   = pos_inc;
            end
        end
        else
        begin
            if (row.len == 3'd0)
            begin
                do_emit   = 1'b1;
                em_status = row.code;
                em_off    = pos_reg;
            end
            else if (row.len == 3'd1)
            begin
                pos_next = pos_inc;
                if (last_of_buffer)
                begin
                    do_emit   = 1'b1;
                    em_status = ST_OK;
                    em_off    = pos_inc;
                end
            end
            else if (last_of_buffer)
            begin
                do_emit   = 1'b1;
                em_status = ST_TRUNC;
                em_off    = pos_reg;
            end
            else
            begin
                start_next = pos_reg;
                len_next   = row.len;
                seen_next  = 3'd1;
                lo_next    = row.lo;
                hi_next    = row.hi;
                ncode_next = row.code;
                pflag_next = 1'b0;
                pcode_next = ST_OK;
                pos_next   = pos_inc;
            end
        end

        // swallow rest of buffer after an error
        if (do_emit && !last_of_buffer)
        begin
            len_next     = 3'd0;
            seen_next    = 3'd0;
            pflag_next   = 1'b0;
            pcode_next   = ST_OK;
            swallow_next = 1'b1;
            pos_next     = pos_inc;
        end

        // end of buffer: back to reset
        if (last_of_buffer)
        begin
            pos_next     = '0;
            start_next   = '0;
            len_next     = 3'd0;
            seen_next    = 3'd0;
            lo_next      = 8'd0;
            hi_next      = 8'd0;
            ncode_next   = ST_OK;
            pcode_next   = ST_OK;
            pflag_next   = 1'b0;
            swallow_next = 1'b0;
        end
    end

    assign emit              = do_emit && !swallow_reg;
    assign result.status     = em_status;
    assign result.bad_offset = to_out(em_off);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            start_reg   <= '0;
            len_reg     <= 3'd0;
            seen_reg    <= 3'd0;
            lo_reg      <= 8'd0;
            hi_reg      <= 8'd0;
            ncode_reg   <= ST_OK;
            pcode_reg   <= ST_OK;
            pflag_reg   <= 1'b0;
            swallow_reg <= 1'b0;
        end
        else if (fire)
        begin
            pos_reg     <= pos_next;
            start_reg   <= start_next;
            len_reg     <= len_next;
            seen_reg    <= seen_next;
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
            ncode_reg   <= ncode_next;
            pcode_reg   <= pcode_next;
            pflag_reg   <= pflag_next;
            swallow_reg <= swallow_next;
        end
    end

endmodule

>>> rtl/utf8v_outreg.sv
// ----------------------------------------------------------------------------
// utf8v_outreg: result register
// Holds one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
module utf8v_outreg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  utf8v_pkg::result_t result,
    output logic               free,
    utf8v_result_if.source     out
);
    import utf8v_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign free = !valid_reg || out.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign out.valid      = valid_reg;
    assign out.status     = data_reg.status;
    assign out.bad_offset = data_reg.bad_offset;

endmodule
